// File: src/msd_pkg.sv
package msd_pkg;

    localparam int DIGITS = 8;
    localparam int IDX_W = $clog2(DIGITS);
    localparam int GRP_W = 14;

    localparam logic [7:0]  DASH_PATTERN = 8'hfd;
    localparam logic [15:0] BLANK_FRAME  = 16'h00ff;
    localparam logic [18:0] GROUP_LIMIT  = 19'd10000;

    // floor(v / 10000) == (v * RECIP_10K) >> RECIP_SHIFT for any 32-bit v
    localparam logic [31:0] RECIP_10K   = 32'hd1b71759;
    localparam int          RECIP_SHIFT = 45;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_TICK  = 2'd1,
        OP_BLANK = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0]       op;
        logic             ovf;
        logic [GRP_W-1:0] hi;
        logic [GRP_W-1:0] lo;
    } msd_groups_t;

    typedef struct packed {
        logic [1:0]      op;
        logic            ovf;
        logic [3:0][3:0] hdig;   // [0] is the thousands digit
        logic [3:0][3:0] ldig;
    } msd_digits_t;

    typedef struct packed {
        logic [3:0]       digit;
        logic [GRP_W-1:0] rem;
    } digit_step_t;

    // One decimal digit off the top of g, unit being 1000, 100 or 10.
    function automatic digit_step_t digit_step(input logic [GRP_W-1:0] g,
                                               input logic [GRP_W-1:0] unit);
        digit_step_t      r;
        logic [GRP_W-1:0] thr;
        r.digit = '0;
        r.rem   = g;
        thr     = '0;
        for (int k = 1; k < 10; k++)
        begin
            thr = thr + unit;
            if (g >= thr)
            begin
                r.digit = 4'(k);
                r.rem   = g - thr;
            end
        end
        return r;
    endfunction

    // Active-low font
    function automatic logic [7:0] seg_font(input logic [3:0] d);
        logic [7:0] s;
        unique case (d)
            4'd0:    s = 8'h03;
            4'd1:    s = 8'h9f;
            4'd2:    s = 8'h25;
            4'd3:    s = 8'h0d;
            4'd4:    s = 8'h99;
            4'd5:    s = 8'h49;
            4'd6:    s = 8'h41;
            4'd7:    s = 8'h1f;
            4'd8:    s = 8'h01;
            4'd9:    s = 8'h09;
            default: s = 8'hff;
        endcase
        return s;
    endfunction

    function automatic logic [15:0] digit_select(input logic [IDX_W-1:0] idx);
        logic [15:0] s;
        unique case (idx)
            3'd0: s = 16'h0800;
            3'd1: s = 16'h0400;
            3'd2: s = 16'h0200;
            3'd3: s = 16'h0100;
            3'd4: s = 16'h8000;
            3'd5: s = 16'h4000;
            3'd6: s = 16'h2000;
            3'd7: s = 16'h1000;
        endcase
        return s;
    endfunction

endpackage

// File: src/msd_split.sv
module msd_split
    import msd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  in_op,
    input  logic [31:0] in_value,
    output logic        out_valid,
    input  logic        out_ready,
    output msd_groups_t out_data
);

    logic             v1_reg;
    logic [1:0]       op1_reg;
    logic [GRP_W-1:0] low1_reg;
    logic [18:0]      q1_reg;
    logic             v2_reg;
    msd_groups_t      grp2_reg;

    logic             ready1;
    logic             ready2;
    logic [63:0]      prod;
    logic [18:0]      q_next;
    logic [GRP_W-1:0] qlo_prod;
    msd_groups_t      grp2_next;

    assign ready2   = !v2_reg || out_ready;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    // stage 1: quotient by 10000 through the reciprocal
    assign prod   = 64'(in_value) * 64'(RECIP_10K);
    assign q_next = prod[RECIP_SHIFT +: 19];

    // stage 2: remainder fits in 14 bits, so only the low bits matter
    assign qlo_prod = GRP_W'(q1_reg[GRP_W-1:0] * 14'd10000);

    always_comb
    begin
        grp2_next.op  = op1_reg;
        grp2_next.ovf = (q1_reg >= GROUP_LIMIT);
        grp2_next.hi  = q1_reg[GRP_W-1:0];
        grp2_next.lo  = low1_reg - qlo_prod;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
                v1_reg <= in_valid;
            if (ready2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && in_valid)
        begin
            op1_reg  <= in_op;
            low1_reg <= in_value[GRP_W-1:0];
            q1_reg   <= q_next;
        end
        if (ready2 && v1_reg)
            grp2_reg <= grp2_next;
    end

    assign out_valid = v2_reg;
    assign out_data  = grp2_reg;

endmodule

// File: src/msd_digits.sv
module msd_digits
    import msd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  msd_groups_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output msd_digits_t out_data
);

    logic             v3_reg;
    logic [1:0]       op3_reg;
    logic             ovf3_reg;
    logic [3:0]       hth3_reg;
    logic [3:0]       lth3_reg;
    logic [GRP_W-1:0] hrem3_reg;
    logic [GRP_W-1:0] lrem3_reg;
    logic             v4_reg;
    msd_digits_t      dig4_reg;

    logic        ready3;
    logic        ready4;
    digit_step_t hth;
    digit_step_t lth;
    digit_step_t hhu;
    digit_step_t lhu;
    digit_step_t hte;
    digit_step_t lte;
    msd_digits_t dig4_next;

    assign ready4   = !v4_reg || out_ready;
    assign ready3   = !v3_reg || ready4;
    assign in_ready = ready3;

    assign hth = digit_step(in_data.hi, 14'd1000);
    assign lth = digit_step(in_data.lo, 14'd1000);

    assign hhu = digit_step(hrem3_reg, 14'd100);
    assign lhu = digit_step(lrem3_reg, 14'd100);
    assign hte = digit_step(hhu.rem, 14'd10);
    assign lte = digit_step(lhu.rem, 14'd10);

    always_comb
    begin
        dig4_next.op      = op3_reg;
        dig4_next.ovf     = ovf3_reg;
        dig4_next.hdig[0] = hth3_reg;
        dig4_next.hdig[1] = hhu.digit;
        dig4_next.hdig[2] = hte.digit;
        dig4_next.hdig[3] = hte.rem[3:0];
        dig4_next.ldig[0] = lth3_reg;
        dig4_next.ldig[1] = lhu.digit;
        dig4_next.ldig[2] = lte.digit;
        dig4_next.ldig[3] = lte.rem[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ready3)
                v3_reg <= in_valid;
            if (ready4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready3 && in_valid)
        begin
            op3_reg   <= in_data.op;
            ovf3_reg  <= in_data.ovf;
            hth3_reg  <= hth.digit;
            lth3_reg  <= lth.digit;
            hrem3_reg <= hth.rem;
            lrem3_reg <= lth.rem;
        end
        if (ready4 && v3_reg)
            dig4_reg <= dig4_next;
    end

    assign out_valid = v4_reg;
    assign out_data  = dig4_reg;

endmodule

// File: src/multiplexed_seven_segment_driver.sv
// Eight-digit multiplexed seven-segment driver.
// Input channel (in_valid / in_stall, op, value): a beat is taken at a clock
// edge with in_valid high and in_stall low. op write converts value to
// decimal and loads the eight segment bytes; op tick advances the scan index
// and emits one frame; op blank emits the all-off frame; op code 3 is dropped.
// Output channel (out_valid / out_stall, frame): frame[15:8] is the one-hot
// digit select, frame[7:0] the active-low segment byte.
// Path: a tick or blank frame reaches out_valid through the input register,
// the divide-by-10000 multiply, remainder, two digit extraction stages and
// the output register. One beat per cycle is accepted while in_stall is low.
// All items pass through the same pipe in order, so a tick always shows the
// segment bytes of every write accepted ahead of it.
// Reset clears the pipe, sets the scan index to 0 (the first tick shows
// digit 1) and loads the font patterns for 0..7 into the segment bytes.
// While out_stall holds a frame, the pipe stages behind it keep filling; the
// input stalls once every stage holds a beat.
module multiplexed_seven_segment_driver
    import msd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] frame
);

    logic        v0_reg;
    logic [1:0]  op0_reg;
    logic [31:0] value0_reg;

    logic [7:0]       store_reg [DIGITS];
    logic [IDX_W-1:0] scan_idx_reg;
    logic [IDX_W-1:0] scan_idx_next;
    logic             out_valid_reg;
    logic [15:0]      frame_reg;

    logic        split_ready;
    logic        grp_valid;
    msd_groups_t grp_data;
    logic        grp_ready;
    logic        dig_valid;
    msd_digits_t dig_data;

    logic out_ready;
    logic take;
    logic write_fire;
    logic tick_fire;
    logic blank_fire;

    assign in_stall = v0_reg && !split_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (!in_stall)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            op0_reg    <= op;
            value0_reg <= value;
        end
    end

    msd_split u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .in_ready  (split_ready),
        .in_op     (op0_reg),
        .in_value  (value0_reg),
        .out_valid (grp_valid),
        .out_ready (grp_ready),
        .out_data  (grp_data)
    );

    msd_digits u_digits (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (grp_valid),
        .in_ready  (grp_ready),
        .in_data   (grp_data),
        .out_valid (dig_valid),
        .out_ready (out_ready),
        .out_data  (dig_data)
    );

    assign out_ready     = !out_valid_reg || !out_stall;
    assign take          = dig_valid && out_ready;
    assign write_fire    = take && (dig_data.op == OP_WRITE);
    assign tick_fire     = take && (dig_data.op == OP_TICK);
    assign blank_fire    = take && (dig_data.op == OP_BLANK);
    assign scan_idx_next = scan_idx_reg + IDX_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGITS; i++)
                store_reg[i] <= seg_font(4'(i));
            scan_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            frame_reg     <= '0;
        end
        else
        begin
            if (write_fire)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    store_reg[i]     <= dig_data.ovf ? DASH_PATTERN
                                                     : seg_font(dig_data.hdig[i]);
                    store_reg[i + 4] <= seg_font(dig_data.ldig[i]);
                end
            end
            if (tick_fire)
                scan_idx_reg <= scan_idx_next;
            if (out_ready)
                out_valid_reg <= tick_fire || blank_fire;
            if (tick_fire)
                frame_reg <= digit_select(scan_idx_next) | {8'h00, store_reg[scan_idx_next]};
            else if (blank_fire)
                frame_reg <= BLANK_FRAME;
        end
    end

    assign out_valid = out_valid_reg;
    assign frame     = frame_reg;

    a_select_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot0(frame_reg[15:8]))
        else $error("digit select not one-hot");

    a_blank_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (frame_reg[15:8] == 8'h00) |-> (frame_reg[7:0] == 8'hff))
        else $error("frame without digit select is not blank");

    a_scan_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !tick_fire |=> $stable(scan_idx_reg))
        else $error("scan index moved without a tick");

    a_tick_frame: assert property (@(posedge clk) disable iff (!rst_n)
        tick_fire |=> out_valid_reg && (frame_reg[15:8] != 8'h00))
        else $error("tick did not produce a digit frame");

endmodule
